// File: rtl/ghst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the generational handle slot table.
// No dependencies; used by every module of the block.
package ghst_pkg;

  // Default number of slots
  localparam int SLOT_COUNT_DEF = 64;

  // Field widths
  localparam int CMD_W   = 3;
  localparam int HIDX_W  = 16;
  localparam int GEN_W   = 16;
  localparam int DIM_W   = 11;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  // Reported count saturates here
  localparam int USED_MAX = 127;

  // Handle index reported on a failed or non-allocating command
  localparam logic [HIDX_W-1:0] NO_INDEX = 16'hffff;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TOUCH   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COUNT   = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL       = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_HANDLE = 2'd2;
  localparam logic [STAT_W-1:0] ST_ZERO_SIZE  = 2'd3;

  // Decoded command class; count and unknown codes only report
  typedef enum logic [2:0] {
    K_ALLOC,
    K_RELEASE,
    K_QUERY,
    K_TOUCH,
    K_REPORT
  } kind_t;

  // Classified item passed from front to back
  typedef struct packed {
    kind_t              kind;
    logic               in_range;
    logic               zero_size;
    logic [HIDX_W-1:0]  hidx;
    logic [GEN_W-1:0]   hgen;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [WORD_W-1:0]  flags;
    logic [WORD_W-1:0]  frame;
  } item_t;

  // One slot memory row
  typedef struct packed {
    logic [GEN_W-1:0]   gen;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [WORD_W-1:0]  flags;
    logic [WORD_W-1:0]  frame;
  } slot_row_t;

endpackage

// File: rtl/generational_handle_slot_table_top.sv
`timescale 1ns / 1ps
// Generational handle slot table: top level joining front end, queue and slot engine.
// Depends on ghst_pkg, ghst_front, ghst_queue and ghst_back.
//
// A table of SLOT_COUNT slots hands out handles (index plus 16-bit generation);
// every command item gives exactly one result item. After reset the slot memory
// is cleared one row a cycle, so the engine starts no item until every row is
// cleared; the two-entry queue may still take up to two items meanwhile.
// A two-entry queue takes items while the engine works. Release, query, touch and
// count (and unknown codes) go through a registered slot memory read, then the
// update and the result register. Allocate searches the used flags 32 slots a cycle
// for the lowest free slot, group by group from the first, then reads and updates
// the found slot row likewise. The engine holds a finished result in its output
// register while the queue keeps filling.
module generational_handle_slot_table_top #(
  parameter int SLOT_COUNT = ghst_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ghst_pkg::CMD_W-1:0]    command,
  input  logic [ghst_pkg::HIDX_W-1:0]   handle_index,
  input  logic [ghst_pkg::GEN_W-1:0]    handle_generation,
  input  logic [ghst_pkg::DIM_W-1:0]    tex_width,
  input  logic [ghst_pkg::DIM_W-1:0]    tex_height,
  input  logic [ghst_pkg::WORD_W-1:0]   tex_flags,
  input  logic [ghst_pkg::WORD_W-1:0]   current_frame,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ghst_pkg::STAT_W-1:0]   status,
  output logic [ghst_pkg::HIDX_W-1:0]   out_index,
  output logic [ghst_pkg::GEN_W-1:0]    out_generation,
  output logic [ghst_pkg::DIM_W-1:0]    out_width,
  output logic [ghst_pkg::DIM_W-1:0]    out_height,
  output logic [ghst_pkg::WORD_W-1:0]   out_flags,
  output logic [ghst_pkg::WORD_W-1:0]   out_last_frame,
  output logic [ghst_pkg::COUNT_W-1:0]  used_count
);

  ghst_pkg::item_t front_item;
  ghst_pkg::item_t q_item;
  logic            q_valid;
  logic            q_ready;

  // Decode and classify
  ghst_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .command           (command),
    .handle_index      (handle_index),
    .handle_generation (handle_generation),
    .tex_width         (tex_width),
    .tex_height        (tex_height),
    .tex_flags         (tex_flags),
    .current_frame     (current_frame),
    .item              (front_item)
  );

  // Item queue
  ghst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (front_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  // Slot engine
  ghst_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_item         (q_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .out_index      (out_index),
    .out_generation (out_generation),
    .out_width      (out_width),
    .out_height     (out_height),
    .out_flags      (out_flags),
    .out_last_frame (out_last_frame),
    .used_count     (used_count)
  );

endmodule

// File: rtl/ghst_front.sv
`timescale 1ns / 1ps
// Front end: decodes the command and checks handle range and size.
// Depends on ghst_pkg.
module ghst_front #(
  parameter int SLOT_COUNT = ghst_pkg::SLOT_COUNT_DEF
) (
  input  logic [ghst_pkg::CMD_W-1:0]  command,
  input  logic [ghst_pkg::HIDX_W-1:0] handle_index,
  input  logic [ghst_pkg::GEN_W-1:0]  handle_generation,
  input  logic [ghst_pkg::DIM_W-1:0]  tex_width,
  input  logic [ghst_pkg::DIM_W-1:0]  tex_height,
  input  logic [ghst_pkg::WORD_W-1:0] tex_flags,
  input  logic [ghst_pkg::WORD_W-1:0] current_frame,
  output ghst_pkg::item_t             item
);

  ghst_pkg::kind_t kind;

  // Command decode
  always_comb begin
    unique case (command)
      ghst_pkg::CMD_ALLOC:   kind = ghst_pkg::K_ALLOC;
      ghst_pkg::CMD_RELEASE: kind = ghst_pkg::K_RELEASE;
      ghst_pkg::CMD_QUERY:   kind = ghst_pkg::K_QUERY;
      ghst_pkg::CMD_TOUCH:   kind = ghst_pkg::K_TOUCH;
      default:               kind = ghst_pkg::K_REPORT;
    endcase
  end

  // Pack classified item
  always_comb begin
    item.kind      = kind;
    item.in_range  = handle_index < ghst_pkg::HIDX_W'(SLOT_COUNT);
    item.zero_size = (tex_width == '0) || (tex_height == '0);
    item.hidx      = handle_index;
    item.hgen      = handle_generation;
    item.width     = tex_width;
    item.height    = tex_height;
    item.flags     = tex_flags;
    item.frame     = current_frame;
  end

endmodule

// File: rtl/ghst_queue.sv
`timescale 1ns / 1ps
// Short item queue decoupling the front end from the slot engine.
// Depends on ghst_pkg.
module ghst_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ghst_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output ghst_pkg::item_t out_item
);

  ghst_pkg::item_t              entries [ghst_pkg::QDEPTH];
  logic [ghst_pkg::QPTR_W-1:0]  wr_ptr;
  logic [ghst_pkg::QPTR_W-1:0]  rd_ptr;
  logic [ghst_pkg::QPTR_W:0]    fill;
  logic                         push;
  logic                         pop;

  assign in_ready  = fill != (ghst_pkg::QPTR_W + 1)'(ghst_pkg::QDEPTH);
  assign out_valid = fill != '0;
  assign out_item  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= in_item;
  end

endmodule

// File: rtl/ghst_back.sv
`timescale 1ns / 1ps
// Slot engine: free-slot search, slot memory read-modify-write, result register.
// Depends on ghst_pkg.
module ghst_back #(
  parameter int SLOT_COUNT = ghst_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  ghst_pkg::item_t               q_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ghst_pkg::STAT_W-1:0]   status,
  output logic [ghst_pkg::HIDX_W-1:0]   out_index,
  output logic [ghst_pkg::GEN_W-1:0]    out_generation,
  output logic [ghst_pkg::DIM_W-1:0]    out_width,
  output logic [ghst_pkg::DIM_W-1:0]    out_height,
  output logic [ghst_pkg::WORD_W-1:0]   out_flags,
  output logic [ghst_pkg::WORD_W-1:0]   out_last_frame,
  output logic [ghst_pkg::COUNT_W-1:0]  used_count
);

  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int GRP    = ((2 ** IDX_W) < 32) ? (2 ** IDX_W) : 32;
  localparam int GRP_W  = $clog2(GRP);
  localparam int NGRP   = (SLOT_COUNT + GRP - 1) / GRP;
  localparam int GCW    = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PADW   = NGRP * GRP;
  localparam int FW     = GCW + GRP_W;
  localparam int SAT_W  = CNT_W + ghst_pkg::COUNT_W;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_SCAN,
    B_EXEC
  } bstate_t;

  bstate_t                    state;
  ghst_pkg::item_t            cur;
  logic [IDX_W-1:0]           sel_idx;
  logic                       full;
  logic [GCW-1:0]             grp;
  logic [IDX_W-1:0]           clr_idx;
  logic [SLOT_COUNT-1:0]      used;
  logic [CNT_W-1:0]           total;

  // Slot memory
  ghst_pkg::slot_row_t        mem [SLOT_COUNT];
  ghst_pkg::slot_row_t        rd_data;
  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  ghst_pkg::slot_row_t        wr_data;

  // Free-slot search over one group of used bits per cycle
  logic [PADW-1:0]            used_pad;
  logic [GRP-1:0]             grp_word [NGRP];
  logic [GCW-1:0]             grp_sel;
  logic [GRP-1:0]             free_bits;
  logic                       hit;
  logic [GRP_W-1:0]           pe;
  logic [FW-1:0]              found_full;
  logic [IDX_W-1:0]           found_idx;
  logic                       last_grp;

  // Execute step
  logic                       fire;
  logic                       handle_ok;
  logic [ghst_pkg::GEN_W-1:0] gen_inc;
  logic [ghst_pkg::GEN_W-1:0] gen_new;
  logic                       alloc_ok;
  logic                       set_used;
  logic                       clr_used;
  logic [CNT_W-1:0]           total_next;
  logic [SAT_W-1:0]           total_ext;
  logic [ghst_pkg::STAT_W-1:0] st_c;
  logic [ghst_pkg::HIDX_W-1:0] idx_c;
  logic [ghst_pkg::GEN_W-1:0]  gen_c;
  logic [ghst_pkg::DIM_W-1:0]  w_c;
  logic [ghst_pkg::DIM_W-1:0]  h_c;
  logic [ghst_pkg::WORD_W-1:0] flags_c;
  logic [ghst_pkg::WORD_W-1:0] frame_c;

  // Padding bits past the table count as used
  assign used_pad = ~(PADW'(~used));

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    assign grp_word[g] = used_pad[g*GRP +: GRP];
  end

  assign grp_sel   = (state == B_IDLE) ? '0 : grp;
  assign free_bits = ~grp_word[grp_sel];
  assign last_grp  = grp_sel == GCW'(NGRP - 1);

  // Lowest free bit in the selected group
  always_comb begin
    hit = 1'b0;
    pe  = '0;
    for (int i = GRP - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit = 1'b1;
        pe  = GRP_W'(i);
      end
    end
  end

  assign found_full = {grp_sel, pe};
  assign found_idx  = found_full[IDX_W-1:0];

  // Pop only from idle; one item at a time
  assign q_ready = (state == B_IDLE);

  // Read port: issued when an item is taken or a search hits
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = found_idx;
    if (state == B_IDLE && q_valid) begin
      rd_en = 1'b1;
      if (q_item.kind != ghst_pkg::K_ALLOC) rd_addr = q_item.hidx[IDX_W-1:0];
    end else if (state == B_SCAN) begin
      rd_en = hit;
    end
  end

  // Execute: result and slot update
  assign fire    = (state == B_EXEC) && (!out_valid || out_ready);
  assign gen_inc = rd_data.gen + 1'b1;
  assign gen_new = (gen_inc == '0) ? ghst_pkg::GEN_W'(1) : gen_inc;
  assign handle_ok = cur.in_range && used[sel_idx] && (rd_data.gen == cur.hgen);
  assign alloc_ok  = !full && !cur.zero_size;

  always_comb begin
    st_c     = ghst_pkg::ST_OK;
    idx_c    = ghst_pkg::NO_INDEX;
    gen_c    = '0;
    w_c      = '0;
    h_c      = '0;
    flags_c  = '0;
    frame_c  = '0;
    set_used = 1'b0;
    clr_used = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = sel_idx;
    wr_data  = rd_data;
    total_next = total;
    if (state == B_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx;
      wr_data = '0;
    end else begin
      case (cur.kind)
        ghst_pkg::K_ALLOC: begin
          if (full) begin
            st_c = ghst_pkg::ST_FULL;
          end else if (cur.zero_size) begin
            st_c = ghst_pkg::ST_ZERO_SIZE;
          end else begin
            idx_c          = ghst_pkg::HIDX_W'(sel_idx);
            gen_c          = gen_new;
            set_used       = fire;
            wr_en          = fire;
            wr_data.gen    = gen_new;
            wr_data.width  = cur.width;
            wr_data.height = cur.height;
            wr_data.flags  = cur.flags;
            wr_data.frame  = cur.frame;
            total_next     = total + 1'b1;
          end
        end
        ghst_pkg::K_RELEASE, ghst_pkg::K_QUERY, ghst_pkg::K_TOUCH: begin
          if (!handle_ok) begin
            st_c = ghst_pkg::ST_BAD_HANDLE;
          end else if (cur.kind == ghst_pkg::K_RELEASE) begin
            clr_used = fire;
            if (total != '0) total_next = total - 1'b1;
          end else if (cur.kind == ghst_pkg::K_QUERY) begin
            w_c     = rd_data.width;
            h_c     = rd_data.height;
            flags_c = rd_data.flags;
            frame_c = rd_data.frame;
          end else begin
            wr_en         = fire;
            wr_data.frame = cur.frame;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign total_ext = SAT_W'(total_next);

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Sequencer, slot flags, count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_idx   <= '0;
      grp       <= '0;
      used      <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      // result held until taken; a new one loads only when the register is free
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IDX_W'(SLOT_COUNT - 1)) state <= B_IDLE;
        end
        B_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            if (q_item.kind == ghst_pkg::K_ALLOC) begin
              sel_idx <= found_idx;
              if (!hit && !last_grp) begin
                full  <= 1'b0;
                grp   <= GCW'(1);
                state <= B_SCAN;
              end else begin
                full  <= !hit;
                state <= B_EXEC;
              end
            end else begin
              full    <= 1'b0;
              sel_idx <= q_item.hidx[IDX_W-1:0];
              state   <= B_EXEC;
            end
          end
        end
        B_SCAN: begin
          sel_idx <= found_idx;
          if (hit) begin
            state <= B_EXEC;
          end else if (last_grp) begin
            full  <= 1'b1;
            state <= B_EXEC;
          end else begin
            grp <= grp + 1'b1;
          end
        end
        B_EXEC: begin
          if (fire) begin
            if (set_used || clr_used) used[sel_idx] <= set_used;
            total          <= total_next;
            status         <= st_c;
            out_index      <= idx_c;
            out_generation <= gen_c;
            out_width      <= w_c;
            out_height     <= h_c;
            out_flags      <= flags_c;
            out_last_frame <= frame_c;
            used_count     <= (total_ext > SAT_W'(ghst_pkg::USED_MAX))
                              ? ghst_pkg::COUNT_W'(ghst_pkg::USED_MAX)
                              : total_ext[ghst_pkg::COUNT_W-1:0];
            state          <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for generational_handle_slot_table_top: a scoreboard
// class predicts each reply from its own copy of the slot table.
// Depends on ghst_pkg and the RTL of the block; nothing else.
module testbench;

  localparam int SLOTS = ghst_pkg::SLOT_COUNT_DEF;
  localparam int RANDOM_ITEMS = 1380;
  localparam int MAX_GAP = 18;
  localparam int PRINT_LIMIT = 20;
  localparam logic [ghst_pkg::CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
  localparam logic [ghst_pkg::CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;

  // One command item as presented on the input side
  typedef struct {
    logic [ghst_pkg::CMD_W-1:0]  command;
    logic [ghst_pkg::HIDX_W-1:0] index;
    logic [ghst_pkg::GEN_W-1:0]  generation;
    logic [ghst_pkg::DIM_W-1:0]  width;
    logic [ghst_pkg::DIM_W-1:0]  height;
    logic [ghst_pkg::WORD_W-1:0] flags;
    logic [ghst_pkg::WORD_W-1:0] frame;
  } cmd_item_t;

  // One reply item as seen on the output side
  typedef struct {
    logic [ghst_pkg::STAT_W-1:0]  status;
    logic [ghst_pkg::HIDX_W-1:0]  index;
    logic [ghst_pkg::GEN_W-1:0]   generation;
    logic [ghst_pkg::DIM_W-1:0]   width;
    logic [ghst_pkg::DIM_W-1:0]   height;
    logic [ghst_pkg::WORD_W-1:0]  flags;
    logic [ghst_pkg::WORD_W-1:0]  last_frame;
    logic [ghst_pkg::COUNT_W-1:0] used;
  } reply_t;

  // Slot table shadow plus the replies it has promised
  class slot_table_scoreboard;
    bit                          used [SLOTS];
    logic [ghst_pkg::GEN_W-1:0]  gen  [SLOTS];
    logic [ghst_pkg::DIM_W-1:0]  wid  [SLOTS];
    logic [ghst_pkg::DIM_W-1:0]  hgt  [SLOTS];
    logic [ghst_pkg::WORD_W-1:0] flg  [SLOTS];
    logic [ghst_pkg::WORD_W-1:0] frm  [SLOTS];
    int unsigned                 live;
    reply_t                      pending_replies [$];
    int unsigned                 mismatch_count;
    int unsigned                 reply_count;
    int unsigned                 status_seen [4];

    function new();
      for (int k = 0; k < SLOTS; k++) begin
        used[k] = 1'b0;
        gen[k]  = '0;
        wid[k]  = '0;
        hgt[k]  = '0;
        flg[k]  = '0;
        frm[k]  = '0;
      end
      live = 0;
      mismatch_count = 0;
      reply_count = 0;
      for (int s = 0; s < 4; s++) status_seen[s] = 0;
    endfunction

    // Apply an accepted command to the shadow table and queue its reply
    function void take_command(cmd_item_t c);
      reply_t r;
      int     k;
      int     slot;
      r.status     = ghst_pkg::ST_OK;
      r.index      = ghst_pkg::NO_INDEX;
      r.generation = '0;
      r.width      = '0;
      r.height     = '0;
      r.flags      = '0;
      r.last_frame = '0;
      if (c.command == ghst_pkg::CMD_ALLOC) begin
        slot = -1;
        for (k = SLOTS - 1; k >= 0; k--) if (!used[k]) slot = k;
        if (slot < 0) begin
          r.status = ghst_pkg::ST_FULL;
        end else if (c.width == '0 || c.height == '0) begin
          r.status = ghst_pkg::ST_ZERO_SIZE;
        end else begin
          // generation skips zero on wrap
          if (gen[slot] == 16'hffff) begin
            gen[slot] = 16'd1;
          end else begin
            gen[slot] = gen[slot] + 16'd1;
          end
          used[slot] = 1'b1;
          wid[slot]  = c.width;
          hgt[slot]  = c.height;
          flg[slot]  = c.flags;
          frm[slot]  = c.frame;
          live++;
          r.index      = ghst_pkg::HIDX_W'(slot);
          r.generation = gen[slot];
        end
      end else if (c.command == ghst_pkg::CMD_RELEASE || c.command == ghst_pkg::CMD_QUERY ||
                   c.command == ghst_pkg::CMD_TOUCH) begin
        k = c.index;
        if (c.index >= SLOTS || !used[k] || gen[k] != c.generation) begin
          r.status = ghst_pkg::ST_BAD_HANDLE;
        end else if (c.command == ghst_pkg::CMD_RELEASE) begin
          used[k] = 1'b0;
          wid[k]  = '0;
          hgt[k]  = '0;
          flg[k]  = '0;
          frm[k]  = '0;
          if (live > 0) live--;
        end else if (c.command == ghst_pkg::CMD_QUERY) begin
          r.width      = wid[k];
          r.height     = hgt[k];
          r.flags      = flg[k];
          r.last_frame = frm[k];
        end else begin
          frm[k] = c.frame;
        end
      end
      r.used = (live > ghst_pkg::USED_MAX) ? ghst_pkg::COUNT_W'(ghst_pkg::USED_MAX)
                                           : ghst_pkg::COUNT_W'(live);
      status_seen[r.status]++;
      pending_replies.push_back(r);
    endfunction

    task report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("%0t ns  MISMATCH %s", $time, msg);
    endtask

    task compare_field(string name, logic [ghst_pkg::WORD_W-1:0] got_v,
                       logic [ghst_pkg::WORD_W-1:0] want_v);
      if (got_v !== want_v)
        report_mismatch($sformatf("reply %0d %s: got 0x%0h, want 0x%0h",
                                  reply_count, name, got_v, want_v));
    endtask

    // Compare a received reply with the oldest one promised
    task check_reply(reply_t got);
      reply_t want;
      reply_count++;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("reply %0d arrived with none outstanding", reply_count));
        return;
      end
      want = pending_replies.pop_front();
      compare_field("status",     got.status,     want.status);
      compare_field("index",      got.index,      want.index);
      compare_field("generation", got.generation, want.generation);
      compare_field("width",      got.width,      want.width);
      compare_field("height",     got.height,     want.height);
      compare_field("flags",      got.flags,      want.flags);
      compare_field("last_frame", got.last_frame, want.last_frame);
      compare_field("used_count", got.used,       want.used);
    endtask
  endclass

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [ghst_pkg::CMD_W-1:0]    command;
  logic [ghst_pkg::HIDX_W-1:0]   handle_index;
  logic [ghst_pkg::GEN_W-1:0]    handle_generation;
  logic [ghst_pkg::DIM_W-1:0]    tex_width;
  logic [ghst_pkg::DIM_W-1:0]    tex_height;
  logic [ghst_pkg::WORD_W-1:0]   tex_flags;
  logic [ghst_pkg::WORD_W-1:0]   current_frame;
  logic                          out_valid;
  logic                          out_ready;
  logic [ghst_pkg::STAT_W-1:0]   status;
  logic [ghst_pkg::HIDX_W-1:0]   out_index;
  logic [ghst_pkg::GEN_W-1:0]    out_generation;
  logic [ghst_pkg::DIM_W-1:0]    out_width;
  logic [ghst_pkg::DIM_W-1:0]    out_height;
  logic [ghst_pkg::WORD_W-1:0]   out_flags;
  logic [ghst_pkg::WORD_W-1:0]   out_last_frame;
  logic [ghst_pkg::COUNT_W-1:0]  used_count;

  slot_table_scoreboard sb = new();
  bit                   no_idle = 1'b0;

  generational_handle_slot_table_top #(
    .SLOT_COUNT(SLOTS)
  ) i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .command           (command),
    .handle_index      (handle_index),
    .handle_generation (handle_generation),
    .tex_width         (tex_width),
    .tex_height        (tex_height),
    .tex_flags         (tex_flags),
    .current_frame     (current_frame),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .out_index         (out_index),
    .out_generation    (out_generation),
    .out_width         (out_width),
    .out_height        (out_height),
    .out_flags         (out_flags),
    .out_last_frame    (out_last_frame),
    .used_count        (used_count)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic cmd_item_t make_cmd(logic [ghst_pkg::CMD_W-1:0] cmd,
                                         logic [ghst_pkg::HIDX_W-1:0] idx,
                                         logic [ghst_pkg::GEN_W-1:0] g,
                                         logic [ghst_pkg::DIM_W-1:0] w,
                                         logic [ghst_pkg::DIM_W-1:0] h,
                                         logic [ghst_pkg::WORD_W-1:0] f,
                                         logic [ghst_pkg::WORD_W-1:0] fr);
    cmd_item_t c;
    c.command    = cmd;
    c.index      = idx;
    c.generation = g;
    c.width      = w;
    c.height     = h;
    c.flags      = f;
    c.frame      = fr;
    return c;
  endfunction

  // Random command; fill mode leans to allocate, drain mode to release
  function automatic cmd_item_t rand_cmd(bit fill);
    cmd_item_t c;
    int        r;
    int        k;
    c = make_cmd(ghst_pkg::CMD_COUNT, ghst_pkg::HIDX_W'($urandom_range(0, 65535)),
                 ghst_pkg::GEN_W'($urandom_range(0, 65535)),
                 ghst_pkg::DIM_W'($urandom_range(1, 1024)),
                 ghst_pkg::DIM_W'($urandom_range(1, 1024)), $urandom, $urandom);
    r = $urandom_range(0, 99);
    if (r < (fill ? 55 : 15)) begin
      c.command = ghst_pkg::CMD_ALLOC;
      case ($urandom_range(0, 9))
        0: c.width  = '0;
        1: c.height = '0;
        2: c.width  = ghst_pkg::DIM_W'($urandom_range(1025, 2047));
        3: c.height = ghst_pkg::DIM_W'($urandom_range(1025, 2047));
        default: ;
      endcase
      return c;
    end else if (r < (fill ? 65 : 60)) begin
      c.command = ghst_pkg::CMD_RELEASE;
    end else if (r < (fill ? 80 : 75)) begin
      c.command = ghst_pkg::CMD_QUERY;
    end else if (r < 90) begin
      c.command = ghst_pkg::CMD_TOUCH;
    end else if (r < 95) begin
      return c;
    end else begin
      c.command = ghst_pkg::CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
      return c;
    end
    // handle: mostly a live one, else stale, off-by-one-bit or out of range
    k = $urandom_range(0, SLOTS - 1);
    if (sb.live != 0 && $urandom_range(0, 99) < 80) begin
      while (!sb.used[k]) k = (k + 1) % SLOTS;
      c.index      = ghst_pkg::HIDX_W'(k);
      c.generation = sb.gen[k];
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          c.index      = ghst_pkg::HIDX_W'(k);
          c.generation = sb.gen[k];
        end
        1: begin
          c.index      = ghst_pkg::HIDX_W'(k);
          c.generation = sb.gen[k] ^
                         (ghst_pkg::GEN_W'(1) << $urandom_range(0, ghst_pkg::GEN_W - 1));
        end
        2: c.index = ghst_pkg::HIDX_W'($urandom_range(SLOTS, 65535));
        default: c.index = ghst_pkg::NO_INDEX;
      endcase
    end
    return c;
  endfunction

  // Present one item, hold it until accepted, then note it in the scoreboard
  task automatic send_cmd(cmd_item_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    command           <= c.command;
    handle_index      <= c.index;
    handle_generation <= c.generation;
    tex_width         <= c.width;
    tex_height        <= c.height;
    tex_flags         <= c.flags;
    current_frame     <= c.frame;
    in_valid          <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_command(c);
    @(negedge clk);
  endtask

  // Reply side: random stall, then take one item
  initial begin
    reply_t got;
    int     stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.status     = status;
      got.index      = out_index;
      got.generation = out_generation;
      got.width      = out_width;
      got.height     = out_height;
      got.flags      = out_flags;
      got.last_frame = out_last_frame;
      got.used       = used_count;
      sb.check_reply(got);
      @(negedge clk);
    end
  end

  // Stimulus and end of run
  initial begin
    int sent;
    int phase_len;
    bit fill;
    rst               = 1'b1;
    in_valid          = 1'b0;
    command           = '0;
    handle_index      = '0;
    handle_generation = '0;
    tex_width         = '0;
    tex_height        = '0;
    tex_flags         = '0;
    current_frame     = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, size extremes, bad handles, unknown codes
    send_cmd(make_cmd(ghst_pkg::CMD_COUNT, '0, '0, '0, '0, '0, '0));
    send_cmd(make_cmd(ghst_pkg::CMD_QUERY, ghst_pkg::NO_INDEX, '0, '0, '0, '0, '0));
    send_cmd(make_cmd(ghst_pkg::CMD_ALLOC, ghst_pkg::NO_INDEX, 16'hffff, 11'd1024, 11'd1,
                      32'hffff_ffff, '0));
    send_cmd(make_cmd(ghst_pkg::CMD_ALLOC, '0, '0, 11'h7ff, 11'h7ff, '0, 32'hffff_ffff));
    send_cmd(make_cmd(ghst_pkg::CMD_ALLOC, '0, '0, '0, 11'd5, 32'h1234_5678, 32'd7));
    send_cmd(make_cmd(ghst_pkg::CMD_ALLOC, '0, '0, 11'd5, '0, 32'h1234_5678, 32'd7));
    send_cmd(make_cmd(ghst_pkg::CMD_ALLOC, '0, '0, '0, '0, '0, '0));
    send_cmd(make_cmd(ghst_pkg::CMD_QUERY, 16'd0, sb.gen[0], '0, '0, '0, '0));
    send_cmd(make_cmd(ghst_pkg::CMD_QUERY, 16'd0, sb.gen[0] + 16'd1, '0, '0, '0, '0));
    send_cmd(make_cmd(ghst_pkg::CMD_TOUCH, 16'd1, sb.gen[1], '0, '0, '0, 32'h5a5a_a5a5));
    send_cmd(make_cmd(ghst_pkg::CMD_QUERY, 16'd1, sb.gen[1], '0, '0, '0, '0));
    send_cmd(make_cmd(ghst_pkg::CMD_RELEASE, 16'd0, sb.gen[0], '0, '0, '0, '0));
    send_cmd(make_cmd(ghst_pkg::CMD_RELEASE, 16'd0, sb.gen[0], '0, '0, '0, '0));
    send_cmd(make_cmd(ghst_pkg::CMD_QUERY, 16'd0, sb.gen[0], '0, '0, '0, '0));
    send_cmd(make_cmd(ghst_pkg::CMD_TOUCH, 16'd0, sb.gen[0], '0, '0, '0, 32'd99));
    send_cmd(make_cmd(ghst_pkg::CMD_QUERY, ghst_pkg::HIDX_W'(SLOTS), 16'd1,
                      '0, '0, '0, '0));
    send_cmd(make_cmd(ghst_pkg::CMD_QUERY, 16'd1, '0, '0, '0, '0, '0));
    for (int u = CMD_UNKNOWN_LO; u <= CMD_UNKNOWN_HI; u++)
      send_cmd(make_cmd(ghst_pkg::CMD_W'(u), 16'd1, sb.gen[1], 11'd3, 11'd3,
                        $urandom, $urandom));
    send_cmd(make_cmd(ghst_pkg::CMD_ALLOC, '0, '0, 11'd1, 11'd1024, 32'h8000_0001,
                      32'h8000_0000));
    send_cmd(make_cmd(ghst_pkg::CMD_COUNT, 16'hffff, 16'hffff, 11'h7ff, 11'h7ff, '1, '1));

    // random phases, alternating fill and drain, some without idling
    sent = 0;
    fill = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(60, 200);
      no_idle   = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < phase_len && sent < RANDOM_ITEMS; j++) begin
        send_cmd(rand_cmd(fill));
        sent++;
      end
      fill = !fill;
    end

    // empty the table, then allocate and read back slot 0
    no_idle = 1'b1;
    for (int k = 0; k < SLOTS; k++)
      if (sb.used[k])
        send_cmd(make_cmd(ghst_pkg::CMD_RELEASE, ghst_pkg::HIDX_W'(k), sb.gen[k],
                          '0, '0, '0, '0));
    send_cmd(make_cmd(ghst_pkg::CMD_ALLOC, '0, '0, 11'd8, 11'd8, $urandom, $urandom));
    send_cmd(make_cmd(ghst_pkg::CMD_QUERY, 16'd0, sb.gen[0], '0, '0, '0, '0));
    in_valid <= 1'b0;

    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("summary: %0d replies checked; ok %0d, table full %0d, bad handle %0d, %s %0d",
             sb.reply_count, sb.status_seen[ghst_pkg::ST_OK],
             sb.status_seen[ghst_pkg::ST_FULL], sb.status_seen[ghst_pkg::ST_BAD_HANDLE],
             "zero size", sb.status_seen[ghst_pkg::ST_ZERO_SIZE]);
    $display("summary: fill and drain phases with random stalls, %0d mismatch(es)",
             sb.mismatch_count);
    if (sb.mismatch_count == 0 && sb.pending_replies.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #80_000_000;
    $display("watchdog expired with %0d replies outstanding", sb.pending_replies.size());
    $display("tb: failure");
    $finish;
  end

endmodule
